// ===== hw/rtl/rpnp_pkg.sv =====
package rpnp_pkg;

	// Parse phase of the current number string.
	typedef enum logic [2:0] {
		PH_START      = 3'd0,
		PH_AFTER_ZERO = 3'd1,
		PH_DIGITS     = 3'd2,
		PH_SUFFIXED   = 3'd3,
		PH_FAILED     = 3'd4
	} phase_t;

	// Number base chosen by the prefix.
	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_OCT = 2'd1,
		RX_HEX = 2'd2
	} radix_t;

	// ASCII codes that the parser recognises.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_UK     = 8'h4B;
	localparam logic [7:0] CH_UM     = 8'h4D;
	localparam logic [7:0] CH_UX     = 8'h58;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_LK     = 8'h6B;
	localparam logic [7:0] CH_LM     = 8'h6D;
	localparam logic [7:0] CH_LX     = 8'h78;

	// Largest digit value of the octal base.
	localparam logic [3:0] OCT_MAX = 4'd7;

	// Suffix shifts: kilo is 2^10, mega is 2^20.
	localparam int KILO_SHIFT = 10;
	localparam int MEGA_SHIFT = 20;

	// Classification of one character.
	typedef struct packed {
		logic       is_nul;
		logic       is_dollar;
		logic       is_zero;
		logic       is_x;
		logic       is_k;
		logic       is_m;
		logic       is_digit;
		logic       is_letter;
		logic [3:0] digit;
	} char_class_t;

endpackage

// ===== hw/rtl/rpnp_char_dec.sv =====
module rpnp_char_dec (
	input  logic [7:0]           char_in,
	output rpnp_pkg::char_class_t cls
);
	import rpnp_pkg::*;

	// Decode the character into flags and a digit value.
	always_comb begin
		cls = '0;
		cls.is_nul    = (char_in == CH_NUL);
		cls.is_dollar = (char_in == CH_DOLLAR);
		cls.is_zero   = (char_in == CH_ZERO);
		cls.is_x      = (char_in == CH_UX) || (char_in == CH_LX);
		cls.is_k      = (char_in == CH_UK) || (char_in == CH_LK);
		cls.is_m      = (char_in == CH_UM) || (char_in == CH_LM);
		if (char_in >= CH_ZERO && char_in <= CH_NINE) begin
			cls.is_digit = 1'b1;
			cls.digit    = 4'(char_in - CH_ZERO);
		end else if (char_in >= CH_LA && char_in <= CH_LF) begin
			cls.is_digit  = 1'b1;
			cls.is_letter = 1'b1;
			cls.digit     = 4'(char_in - CH_LA + 8'd10);
		end else if (char_in >= CH_UA && char_in <= CH_UF) begin
			cls.is_digit  = 1'b1;
			cls.is_letter = 1'b1;
			cls.digit     = 4'(char_in - CH_UA + 8'd10);
		end
	end

endmodule

// ===== hw/rtl/rpnp_step.sv =====
module rpnp_step #(
	parameter int VALUE_BITS = 32
) (
	input  rpnp_pkg::char_class_t  cls,
	input  rpnp_pkg::phase_t       phase,
	input  rpnp_pkg::radix_t       radix,
	input  logic [VALUE_BITS-1:0]  accum,
	output rpnp_pkg::phase_t       phase_nx,
	output rpnp_pkg::radix_t       radix_nx,
	output logic [VALUE_BITS-1:0]  accum_nx,
	output logic                   emit,
	output logic                   bad
);
	import rpnp_pkg::*;

	logic                  take;
	radix_t                take_rx;
	logic                  digit_ok;
	logic [VALUE_BITS-1:0] dig_ext;
	logic [VALUE_BITS-1:0] scaled;

	// Decide whether this character goes through the digit handling, and in which base.
	always_comb begin
		take    = 1'b0;
		take_rx = radix;
		unique case (phase)
			PH_START: begin
				take    = !cls.is_dollar && !cls.is_zero;
				take_rx = RX_DEC;
			end
			PH_AFTER_ZERO: take = !cls.is_x;
			PH_DIGITS:     take = 1'b1;
			default:       take = 1'b0;
		endcase
	end

	// A digit is valid when it fits the base; letters only fit hex.
	assign digit_ok = cls.is_digit && ((take_rx == RX_HEX) ||
		(!cls.is_letter && ((take_rx == RX_DEC) || (cls.digit <= OCT_MAX))));
	assign dig_ext  = VALUE_BITS'(cls.digit);

	// Multiply the accumulator by the base with shifts, and one add for decimal.
	always_comb begin
		unique case (take_rx)
			RX_HEX:  scaled = accum << 4;
			RX_OCT:  scaled = accum << 3;
			default: scaled = (accum << 3) + (accum << 1);
		endcase
	end

	// Next state and result for the character.
	always_comb begin
		phase_nx = phase;
		radix_nx = radix;
		accum_nx = accum;
		emit     = 1'b0;
		bad      = 1'b0;
		if (cls.is_nul) begin
			emit     = 1'b1;
			bad      = !(phase == PH_START || phase == PH_AFTER_ZERO ||
				phase == PH_DIGITS || phase == PH_SUFFIXED);
			phase_nx = PH_START;
			radix_nx = RX_DEC;
			accum_nx = '0;
		end else begin
			unique case (phase)
				PH_START: begin
					if (cls.is_dollar) begin
						radix_nx = RX_HEX;
						phase_nx = PH_DIGITS;
					end else if (cls.is_zero) begin
						radix_nx = RX_OCT;
						phase_nx = PH_AFTER_ZERO;
					end else begin
						radix_nx = RX_DEC;
						phase_nx = PH_DIGITS;
					end
				end
				PH_AFTER_ZERO: begin
					phase_nx = PH_DIGITS;
					if (cls.is_x) begin
						radix_nx = RX_HEX;
					end
				end
				default: begin
				end
			endcase
			// Digit handling overrides the phase where it applies.
			if (take) begin
				priority if (digit_ok) begin
					accum_nx = scaled + dig_ext;
				end else if (cls.is_digit) begin
					phase_nx = PH_FAILED;
				end else if (cls.is_k) begin
					accum_nx = accum << KILO_SHIFT;
					phase_nx = PH_SUFFIXED;
				end else if (cls.is_m) begin
					accum_nx = accum << MEGA_SHIFT;
					phase_nx = PH_SUFFIXED;
				end else begin
					phase_nx = PH_FAILED;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/radix_prefixed_number_parser.sv =====
// Channel  | Handshake                  | Payload
// ---------+----------------------------+----------------------------
// input    | char_valid / char_ready    | char_in[7:0]
// result   | result_valid / result_ready| value[31:0], status
//
// Each item is registered, then decoded and applied to the parse state combinationally.
// One item per cycle sustained unless the input register stalls; a zero byte's result item
// is loaded into the result register as it leaves the input register. The input register
// stalls only when it holds a zero byte, the result register is full and result_ready is low.
// Reset (arst_n low) clears the parse state to the start of a decimal number, value zero.
// Characters other than the zero byte produce no result item.
module radix_prefixed_number_parser #(
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_in,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] value,
	output logic        status
);
	import rpnp_pkg::*;

	logic                  v_s1;
	logic [7:0]            char_s1;
	phase_t                phase_q;
	radix_t                radix_q;
	logic [VALUE_BITS-1:0] accum_q;
	logic                  out_v_q;
	logic [31:0]           value_q;
	logic                  status_q;

	char_class_t           cls;
	phase_t                phase_nx;
	radix_t                radix_nx;
	logic [VALUE_BITS-1:0] accum_nx;
	logic                  emit;
	logic                  bad;
	logic                  adv;
	logic                  out_free;

	// The result register can be loaded when empty or being emptied.
	assign out_free   = !out_v_q || result_ready;
	assign adv        = v_s1 && (!cls.is_nul || out_free);
	assign char_ready = !v_s1 || adv;

	rpnp_char_dec u_dec (
		.char_in (char_s1),
		.cls     (cls)
	);

	rpnp_step #(
		.VALUE_BITS (VALUE_BITS)
	) u_step (
		.cls      (cls),
		.phase    (phase_q),
		.radix    (radix_q),
		.accum    (accum_q),
		.phase_nx (phase_nx),
		.radix_nx (radix_nx),
		.accum_nx (accum_nx),
		.emit     (emit),
		.bad      (bad)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (char_ready) begin
			v_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			char_s1 <= char_in;
		end
	end

	// Parse state, updated once for each item leaving the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			radix_q <= RX_DEC;
			accum_q <= '0;
		end else if (adv) begin
			phase_q <= phase_nx;
			radix_q <= radix_nx;
			accum_q <= accum_nx;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			value_q  <= bad ? 32'd0 : 32'(accum_q);
			status_q <= bad;
		end
	end

	assign result_valid = out_v_q;
	assign value        = value_q;
	assign status       = status_q;

	// An error result always carries a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status |-> value == 32'd0)
		else $error("error result with nonzero value");

	// A terminator returns the parser to its reset state.
	a_term_reset: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cls.is_nul |=> phase_q == PH_START && radix_q == RX_DEC && accum_q == '0)
		else $error("parse state not cleared after terminator");

	// A blocked terminator holds the input register.
	a_term_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && cls.is_nul && out_v_q && !result_ready |-> !char_ready)
		else $error("input accepted while terminator is blocked");

	// The phase after a leading zero always has the octal base.
	a_oct_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_AFTER_ZERO |-> radix_q == RX_OCT)
		else $error("leading zero phase without octal base");

endmodule
